// ===== design/imuai_pkg.sv =====
// ----------------------------------------------------------------------------
// imuai_pkg
// Shared types, constants and control codes of the IMU angle integrator.
// ----------------------------------------------------------------------------
package imuai_pkg;

  // One full turn in angle units (360 deg * 131 counts * 1000 ms)
  localparam logic [27:0] FULL_TURN       = 28'd47160000;
  localparam logic [7:0]  MAX_CAL_SAMPLES = 8'd255;
  localparam int          NUM_AXES        = 3;
  localparam int          NUM_OFS         = 6;
  localparam int          DIV_BITS        = 24;

  // Transaction modes
  typedef enum logic [2:0] {
    MODE_SAMPLE   = 3'd0,
    MODE_CAL      = 3'd1,
    MODE_LOAD_OFS = 3'd2,
    MODE_CLR_ANG  = 3'd3,
    MODE_CLR_PEAK = 3'd4
  } mode_t;

  // Controller states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_EXEC     = 8'b0000_0010,
    ST_MUL      = 8'b0000_0100,
    ST_ADD      = 8'b0000_1000,
    ST_DIV_INIT = 8'b0001_0000,
    ST_DIV_STEP = 8'b0010_0000,
    ST_DIV_WR   = 8'b0100_0000,
    ST_EMIT     = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic [31:0]        time_ms;
    logic [2:0]         axis_mask;
  } in_t;

  typedef struct packed {
    logic [25:0]        angle_x;
    logic [25:0]        angle_y;
    logic [25:0]        angle_z;
    logic signed [15:0] corrected_x;
    logic signed [15:0] corrected_y;
    logic signed [15:0] corrected_z;
    logic [15:0]        peak_x;
    logic [15:0]        peak_y;
    logic [15:0]        peak_z;
    logic               calibrating;
    logic               calibration_done;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_in;
    logic       exec;
    logic       mul;
    logic       add;
    logic       div_init;
    logic       div_step;
    logic       div_wr;
    logic       emit;
    logic [1:0] axis;
    logic [2:0] ofs;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_sample;
    logic in_cal;
    logic cal_end;
    logic seen;
  } stat_t;

endpackage

// ===== design/imu_angle_integrator_with_calibration.sv =====
// ----------------------------------------------------------------------------
// imu_angle_integrator_with_calibration
// Gyro rate integration into three wrapped angles with bias calibration.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one transaction per
//   IMU item: a sample, a calibration start, an offset load or a clear.
//   Every input transaction gives exactly one result transaction on the
//   output channel (out_valid / out_stall / out_data).
//   cfg_we / cfg_data write the calibration sample count; write it only
//   while the block is idle.
// Work per transaction, after the accepting edge:
//   sample with integration: one shared multiplier, one axis at a time,
//     a multiply step and then an add step per axis
//   sample that ends a calibration run: one shared restoring divider,
//     an init step, one step per quotient bit and a write step per offset, six offsets
//   all other transactions, the first sample included: the execute step only
// One transaction is in work at a time; in_stall drops with out_valid rising,
//   so the next one can be taken in that same cycle.
// A new transaction is accepted while the previous result still waits in the
// output register; its result is held back until that register is free.
// Reset (synchronous, rst_n low) clears angles, peaks, offsets, sums and
// the count register, and drops out_valid.
// ----------------------------------------------------------------------------
module imu_angle_integrator_with_calibration (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  imuai_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output imuai_pkg::out_t out_data,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_data
);

  imuai_pkg::cmd_t  cmd;
  imuai_pkg::stat_t stat;

  imuai_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  imuai_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ===== design/imuai_ctrl.sv =====
// ----------------------------------------------------------------------------
// imuai_ctrl
// Sequencer: handshakes, per-axis integration steps and offset division steps.
// ----------------------------------------------------------------------------
module imuai_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  imuai_pkg::stat_t stat,
  output imuai_pkg::cmd_t  cmd
);

  imuai_pkg::state_t state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [2:0] ofs_r, ofs_nxt;
  logic [4:0] bit_r, bit_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       emit_ok;

  assign in_stall  = (state_r != imuai_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign emit_ok   = !out_valid_r || !out_stall;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    axis_nxt     = axis_r;
    ofs_nxt      = ofs_r;
    bit_nxt      = bit_r;
    cmd          = '0;
    cmd.axis     = axis_r;
    cmd.ofs      = ofs_r;
    unique case (state_r)
      imuai_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = imuai_pkg::ST_EXEC;
        end
      end
      imuai_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        axis_nxt = 2'd0;
        ofs_nxt  = 3'd0;
        if (stat.is_sample && stat.in_cal && stat.cal_end) begin
          state_nxt = imuai_pkg::ST_DIV_INIT;
        end else if (stat.is_sample && !stat.in_cal && stat.seen) begin
          state_nxt = imuai_pkg::ST_MUL;
        end else begin
          state_nxt = imuai_pkg::ST_EMIT;
        end
      end
      imuai_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = imuai_pkg::ST_ADD;
      end
      imuai_pkg::ST_ADD: begin
        cmd.add = 1'b1;
        if (axis_r == 2'(imuai_pkg::NUM_AXES - 1)) begin
          state_nxt = imuai_pkg::ST_EMIT;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = imuai_pkg::ST_MUL;
        end
      end
      imuai_pkg::ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        bit_nxt      = 5'd0;
        state_nxt    = imuai_pkg::ST_DIV_STEP;
      end
      imuai_pkg::ST_DIV_STEP: begin
        cmd.div_step = 1'b1;
        bit_nxt      = bit_r + 5'd1;
        if (bit_r == 5'(imuai_pkg::DIV_BITS - 1)) begin
          state_nxt = imuai_pkg::ST_DIV_WR;
        end
      end
      imuai_pkg::ST_DIV_WR: begin
        cmd.div_wr = 1'b1;
        if (ofs_r == 3'(imuai_pkg::NUM_OFS - 1)) begin
          state_nxt = imuai_pkg::ST_EMIT;
        end else begin
          ofs_nxt   = ofs_r + 3'd1;
          state_nxt = imuai_pkg::ST_DIV_INIT;
        end
      end
      imuai_pkg::ST_EMIT: begin
        if (emit_ok) begin
          cmd.emit  = 1'b1;
          state_nxt = imuai_pkg::ST_IDLE;
        end
      end
      default: state_nxt = imuai_pkg::ST_IDLE;
    endcase
  end

  // output valid: set on emit, cleared when the result transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= imuai_pkg::ST_IDLE;
      axis_r      <= '0;
      ofs_r       <= '0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      ofs_r       <= ofs_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/imuai_dp.sv =====
// ----------------------------------------------------------------------------
// imuai_dp
// Datapath: state stores, offset correction, rate multiply, angle wrap and
// a shared restoring divider for the calibration averages.
// ----------------------------------------------------------------------------
module imuai_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data,
  input  imuai_pkg::in_t   in_data,
  input  imuai_pkg::cmd_t  cmd,
  output imuai_pkg::stat_t stat,
  output imuai_pkg::out_t  out_data
);

  imuai_pkg::in_t     in_r;
  imuai_pkg::out_t    out_r;
  logic [7:0]         cfg_r;
  logic [25:0]        angle_r  [imuai_pkg::NUM_AXES];
  logic [15:0]        peak_r   [imuai_pkg::NUM_AXES];
  logic signed [15:0] corr_r   [imuai_pkg::NUM_AXES];
  logic signed [15:0] off_r    [imuai_pkg::NUM_OFS];
  logic signed [23:0] sum_r    [imuai_pkg::NUM_OFS];
  logic [7:0]         samples_r;
  logic               in_cal_r;
  logic               seen_r;
  logic [31:0]        last_time_r;
  logic               done_r;
  logic [7:0]         dt_r;
  logic signed [25:0] prod_r;
  logic [7:0]         rem_r;
  logic [23:0]        quo_r;
  logic               neg_r;

  logic signed [15:0] raw [imuai_pkg::NUM_OFS];
  logic [7:0]         samples_inc;
  logic [31:0]        elapsed;
  logic [7:0]         dt;
  logic signed [15:0] corr_c [imuai_pkg::NUM_AXES];
  logic [15:0]        mag    [imuai_pkg::NUM_AXES];
  logic signed [16:0] rate_d;
  logic signed [25:0] prod_c;
  logic signed [27:0] acc;
  logic [25:0]        acc_w;
  logic signed [23:0] sum_sel;
  logic [7:0]         div_n;
  logic [8:0]         shifted;
  logic               q_bit;
  logic [15:0]        q16;
  imuai_pkg::mode_t   mode;

  assign mode   = imuai_pkg::mode_t'(in_r.mode);
  assign raw[0] = in_r.accel_x;
  assign raw[1] = in_r.accel_y;
  assign raw[2] = in_r.accel_z;
  assign raw[3] = in_r.rate_x;
  assign raw[4] = in_r.rate_y;
  assign raw[5] = in_r.rate_z;

  // calibration run end test
  assign samples_inc = samples_r + 8'd1;
  assign stat.is_sample = (mode == imuai_pkg::MODE_SAMPLE);
  assign stat.in_cal    = in_cal_r;
  assign stat.seen      = seen_r;
  assign stat.cal_end   = (samples_inc >= cfg_r) || (samples_inc >= imuai_pkg::MAX_CAL_SAMPLES);

  // elapsed time, saturated to 8 bits
  assign elapsed = in_r.time_ms - last_time_r;
  assign dt      = (|elapsed[31:8]) ? 8'hFF : elapsed[7:0];

  // corrected acceleration and its magnitude
  always_comb begin
    for (int i = 0; i < imuai_pkg::NUM_AXES; i++) begin
      corr_c[i] = raw[i] - off_r[i];
      mag[i]    = corr_c[i][15] ? (16'd0 - corr_c[i]) : corr_c[i];
    end
  end

  // rate times elapsed time for the selected axis
  assign rate_d = {raw[3 + cmd.axis][15], raw[3 + cmd.axis]}
                - {off_r[3 + cmd.axis][15], off_r[3 + cmd.axis]};
  assign prod_c = rate_d * $signed({1'b0, dt_r});

  // angle add with one-turn wrap
  always_comb begin
    acc = $signed({2'b00, angle_r[cmd.axis]}) + $signed({{2{prod_r[25]}}, prod_r});
    if (acc >= $signed(imuai_pkg::FULL_TURN)) begin
      acc_w = 26'(acc - $signed(imuai_pkg::FULL_TURN));
    end else if (acc < 0) begin
      acc_w = 26'(acc + $signed(imuai_pkg::FULL_TURN));
    end else begin
      acc_w = acc[25:0];
    end
  end

  // divider step
  assign sum_sel = sum_r[cmd.ofs];
  assign div_n   = (samples_r == 8'd0) ? 8'd1 : samples_r;
  assign shifted = {rem_r, quo_r[23]};
  assign q_bit   = (shifted >= {1'b0, div_n});
  assign q16     = neg_r ? (16'd0 - quo_r[15:0]) : quo_r[15:0];

  // input and work registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.exec) begin
      dt_r <= dt;
    end
    if (cmd.mul) begin
      prod_r <= prod_c;
    end
    if (cmd.div_init) begin
      neg_r <= sum_sel[23];
      quo_r <= sum_sel[23] ? (24'd0 - sum_sel) : sum_sel;
      rem_r <= 8'd0;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? 8'(shifted - {1'b0, div_n}) : shifted[7:0];
      quo_r <= {quo_r[22:0], q_bit};
    end
    if (cmd.emit) begin
      out_r.angle_x          <= angle_r[0];
      out_r.angle_y          <= angle_r[1];
      out_r.angle_z          <= angle_r[2];
      out_r.corrected_x      <= corr_r[0];
      out_r.corrected_y      <= corr_r[1];
      out_r.corrected_z      <= corr_r[2];
      out_r.peak_x           <= peak_r[0];
      out_r.peak_y           <= peak_r[1];
      out_r.peak_z           <= peak_r[2];
      out_r.calibrating      <= in_cal_r;
      out_r.calibration_done <= done_r;
    end
  end

  assign out_data = out_r;

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      samples_r   <= '0;
      in_cal_r    <= 1'b0;
      seen_r      <= 1'b0;
      last_time_r <= '0;
      done_r      <= 1'b0;
      for (int i = 0; i < imuai_pkg::NUM_AXES; i++) begin
        angle_r[i] <= '0;
        peak_r[i]  <= '0;
        corr_r[i]  <= '0;
      end
      for (int i = 0; i < imuai_pkg::NUM_OFS; i++) begin
        off_r[i] <= '0;
        sum_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_data;
      end
      if (cmd.exec) begin
        done_r <= 1'b0;
        unique case (mode)
          imuai_pkg::MODE_SAMPLE: begin
            if (in_cal_r) begin
              for (int i = 0; i < imuai_pkg::NUM_OFS; i++) begin
                sum_r[i] <= sum_r[i] + 24'(raw[i]);
              end
              samples_r <= samples_inc;
              if (stat.cal_end) begin
                in_cal_r <= 1'b0;
                done_r   <= 1'b1;
              end
            end else begin
              for (int i = 0; i < imuai_pkg::NUM_AXES; i++) begin
                corr_r[i] <= corr_c[i];
                if (mag[i] > peak_r[i]) begin
                  peak_r[i] <= mag[i];
                end
              end
              last_time_r <= in_r.time_ms;
              seen_r      <= 1'b1;
            end
          end
          imuai_pkg::MODE_CAL: begin
            if (cfg_r != 8'd0) begin
              for (int i = 0; i < imuai_pkg::NUM_OFS; i++) begin
                sum_r[i] <= '0;
              end
              samples_r <= '0;
              in_cal_r  <= 1'b1;
            end
          end
          imuai_pkg::MODE_LOAD_OFS: begin
            for (int i = 0; i < imuai_pkg::NUM_OFS; i++) begin
              off_r[i] <= raw[i];
            end
          end
          imuai_pkg::MODE_CLR_ANG: begin
            for (int i = 0; i < imuai_pkg::NUM_AXES; i++) begin
              if (in_r.axis_mask[i]) angle_r[i] <= '0;
            end
          end
          imuai_pkg::MODE_CLR_PEAK: begin
            for (int i = 0; i < imuai_pkg::NUM_AXES; i++) begin
              if (in_r.axis_mask[i]) peak_r[i] <= '0;
            end
          end
          default: ;
        endcase
      end
      if (cmd.add) begin
        angle_r[cmd.axis] <= acc_w;
      end
      if (cmd.div_wr) begin
        off_r[cmd.ofs] <= $signed(q16);
      end
    end
  end

endmodule

// ===== design/imuai_chk.sv =====
// ----------------------------------------------------------------------------
// imuai_chk
// Port-level checks of the IMU angle integrator, bound to the top level.
// ----------------------------------------------------------------------------
module imuai_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input imuai_pkg::out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one transaction in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  // a finished run is no longer calibrating
  a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.calibration_done && out_data.calibrating))
    else $error("done and calibrating together");

  // angles stay within one turn
  a_angle_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({2'b00, out_data.angle_x} < imuai_pkg::FULL_TURN)
               && ({2'b00, out_data.angle_y} < imuai_pkg::FULL_TURN)
               && ({2'b00, out_data.angle_z} < imuai_pkg::FULL_TURN))
    else $error("angle out of range");

  // peaks never exceed the largest magnitude
  a_peak_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.peak_x <= 16'd32768) && (out_data.peak_y <= 16'd32768)
               && (out_data.peak_z <= 16'd32768))
    else $error("peak out of range");

endmodule

bind imu_angle_integrator_with_calibration imuai_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== verif/tb_imu_angle_integrator_with_calibration.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_imu_angle_integrator_with_calibration
// Self-checking bench for the IMU angle integrator. A short stimulus table
// covers extremes, every mode and first-sample timing; directed runs cover
// calibration start, end, restart and mid-run loads; random sample streams
// and calibration runs follow. Every result transaction is checked field by
// field, typed table rows against the table, others against an in-bench angle/offset/peak tracker.
// ----------------------------------------------------------------------------
module tb_imu_angle_integrator_with_calibration;

  localparam int FULL_TURN_I = 47160000;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  imuai_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  imuai_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;

  imu_angle_integrator_with_calibration i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Tracker state
  int   ang[3];
  int   peak[3];
  int   corr[3];
  int   ofs[6];
  int   sums[6];
  int   n_taken;
  bit   cal_active;
  bit   have_time_base;
  logic [31:0] prev_time;
  int   cal_count;

  imuai_pkg::out_t expected_q[$];
  int   err_count = 0;
  int   cycle_count = 0;
  bit   quiet = 1'b0;  // no random idling on either side

  function automatic int wrap16(int v);
    return int'(signed'(v[15:0]));
  endfunction

  function automatic imuai_pkg::out_t track_item(imuai_pkg::in_t t);
    int raw[6];
    int dt, c, a, n;
    bit done;
    imuai_pkg::out_t r;
    done = 1'b0;
    raw[0] = t.accel_x; raw[1] = t.accel_y; raw[2] = t.accel_z;
    raw[3] = t.rate_x;  raw[4] = t.rate_y;  raw[5] = t.rate_z;
    case (t.mode)
      imuai_pkg::MODE_SAMPLE: begin
        if (cal_active) begin
          for (int i = 0; i < 6; i++) sums[i] += raw[i];
          n_taken = (n_taken + 1) & 255;
          if (n_taken >= cal_count || n_taken >= 255) begin
            n = (n_taken == 0) ? 1 : n_taken;
            for (int i = 0; i < 6; i++) ofs[i] = wrap16(sums[i] / n);
            cal_active = 1'b0;
            done = 1'b1;
          end
        end else begin
          dt = ((t.time_ms - prev_time) > 32'd255) ? 255 : int'(t.time_ms - prev_time);
          for (int i = 0; i < 3; i++) begin
            c = wrap16(raw[i] - ofs[i]);
            corr[i] = c;
            if ((c < 0 ? -c : c) > peak[i]) peak[i] = (c < 0 ? -c : c);
          end
          if (have_time_base)
            for (int i = 0; i < 3; i++) begin
              a = ang[i] + (raw[3+i] - ofs[3+i]) * dt;
              if (a >= FULL_TURN_I) a -= FULL_TURN_I;
              else if (a < 0) a += FULL_TURN_I;
              ang[i] = a;
            end
          prev_time = t.time_ms;
          have_time_base = 1'b1;
        end
      end
      imuai_pkg::MODE_CAL: begin
        if (cal_count != 0) begin
          for (int i = 0; i < 6; i++) sums[i] = 0;
          n_taken = 0;
          cal_active = 1'b1;
        end
      end
      imuai_pkg::MODE_LOAD_OFS: for (int i = 0; i < 6; i++) ofs[i] = raw[i];
      imuai_pkg::MODE_CLR_ANG:  for (int i = 0; i < 3; i++) if (t.axis_mask[i]) ang[i] = 0;
      imuai_pkg::MODE_CLR_PEAK: for (int i = 0; i < 3; i++) if (t.axis_mask[i]) peak[i] = 0;
      default: ;
    endcase
    r.angle_x = 26'(ang[0]); r.angle_y = 26'(ang[1]); r.angle_z = 26'(ang[2]);
    r.corrected_x = 16'(corr[0]); r.corrected_y = 16'(corr[1]);
    r.corrected_z = 16'(corr[2]);
    r.peak_x = 16'(peak[0]); r.peak_y = 16'(peak[1]); r.peak_z = 16'(peak[2]);
    r.calibrating = cal_active;
    r.calibration_done = done;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch @%0t: %s got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("imu_angle_integrator_with_calibration regression: fail");
      $finish;
    end
  end

  // Result side: random stall, compare against oldest expectation
  always @(posedge clk) begin
    imuai_pkg::out_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = expected_q.pop_front();
        if (out_data.angle_x != w.angle_x) report_mismatch("angle_x", out_data.angle_x, w.angle_x);
        if (out_data.angle_y != w.angle_y) report_mismatch("angle_y", out_data.angle_y, w.angle_y);
        if (out_data.angle_z != w.angle_z) report_mismatch("angle_z", out_data.angle_z, w.angle_z);
        if (out_data.corrected_x != w.corrected_x)
          report_mismatch("corrected_x", out_data.corrected_x, w.corrected_x);
        if (out_data.corrected_y != w.corrected_y)
          report_mismatch("corrected_y", out_data.corrected_y, w.corrected_y);
        if (out_data.corrected_z != w.corrected_z)
          report_mismatch("corrected_z", out_data.corrected_z, w.corrected_z);
        if (out_data.peak_x != w.peak_x) report_mismatch("peak_x", out_data.peak_x, w.peak_x);
        if (out_data.peak_y != w.peak_y) report_mismatch("peak_y", out_data.peak_y, w.peak_y);
        if (out_data.peak_z != w.peak_z) report_mismatch("peak_z", out_data.peak_z, w.peak_z);
        if (out_data.calibrating != w.calibrating)
          report_mismatch("calibrating", out_data.calibrating, w.calibrating);
        if (out_data.calibration_done != w.calibration_done)
          report_mismatch("calibration_done", out_data.calibration_done, w.calibration_done);
      end
    end
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 29);
  end

  // Send one transaction; random idle before it. in_valid stays high after
  // the accepting edge; the next send or an explicit drop takes it down.
  task automatic send_item(imuai_pkg::in_t t, bit typed, imuai_pkg::out_t typed_res);
    imuai_pkg::out_t p;
    while (!quiet && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = track_item(t);
    // typed rows are checked against the value written in the table
    expected_q.push_back(typed ? typed_res : p);
  endtask

  task automatic write_count(int v);
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v[7:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cal_count = v;
  endtask

  function automatic imuai_pkg::in_t mk(imuai_pkg::mode_t m, int ax, int ay, int az,
                                        int rx, int ry, int rz,
                                        logic [31:0] tm, logic [2:0] msk);
    imuai_pkg::in_t t;
    t.mode = m; t.accel_x = 16'(ax); t.accel_y = 16'(ay); t.accel_z = 16'(az);
    t.rate_x = 16'(rx); t.rate_y = 16'(ry); t.rate_z = 16'(rz);
    t.time_ms = tm; t.axis_mask = msk;
    return t;
  endfunction

  function automatic imuai_pkg::in_t rand_item();
    return imuai_pkg::in_t'(134'({$urandom, $urandom, $urandom, $urandom, $urandom}));
  endfunction

  function automatic imuai_pkg::in_t rand_sample(logic [31:0] tm);
    imuai_pkg::in_t t;
    t = rand_item();
    t.mode = imuai_pkg::MODE_SAMPLE;
    t.time_ms = tm;
    return t;
  endfunction

  typedef struct {
    imuai_pkg::in_t  item;
    bit              typed;
    imuai_pkg::out_t res;
  } row_t;

  initial begin
    row_t rows[$];
    row_t rw;
    imuai_pkg::out_t z;
    imuai_pkg::in_t t;
    logic [31:0] now;
    int k, guard;
    z = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 3; i++) begin ang[i] = 0; peak[i] = 0; corr[i] = 0; end
    for (int i = 0; i < 6; i++) begin ofs[i] = 0; sums[i] = 0; end
    n_taken = 0; cal_active = 0; have_time_base = 0; prev_time = 0; cal_count = 0;
    @(posedge clk);

    // Directed table
    // start with zero count register is ignored: all-zero result
    rw.item = mk(imuai_pkg::MODE_CAL, 0, 0, 0, 0, 0, 0, 0, 0);
    rw.typed = 1; rw.res = z; rows.push_back(rw);
    // first sample sets the time base and does not integrate
    rw.item = mk(imuai_pkg::MODE_SAMPLE, -32768, 32767, 0, 32767, -32768, 1,
                 32'hFFFF_FF00, 7);
    rw.typed = 1; rw.res = z;
    rw.res.corrected_x = 16'h8000; rw.res.corrected_y = 16'h7FFF;
    rw.res.peak_x = 16'd32768; rw.res.peak_y = 16'd32767;
    rows.push_back(rw);
    rw.typed = 0;
    // time wrap, saturated elapsed time, extremes of rate
    rw.item = mk(imuai_pkg::MODE_SAMPLE, 1, -1, 0, 32767, -32768, 100, 32'h0000_0100, 0);
    rows.push_back(rw);
    rw.item = mk(imuai_pkg::MODE_SAMPLE, 0, 0, 0, -32768, 32767, -100, 32'h0000_0101, 0);
    rows.push_back(rw);
    rw.item = mk(imuai_pkg::MODE_SAMPLE, 0, 0, 0, -32768, -32768, -32768, 32'h0000_01FF, 0);
    rows.push_back(rw);
    // offset load to extremes, then 17-bit differences
    rw.item = mk(imuai_pkg::MODE_LOAD_OFS, 32767, -32768, 1, -32768, 32767, 0, 0, 0);
    rows.push_back(rw);
    rw.item = mk(imuai_pkg::MODE_SAMPLE, -32768, 32767, -32768, 32767, -32768, 5,
                 32'h0000_02FF, 0);
    rows.push_back(rw);
    rw.item = mk(imuai_pkg::MODE_SAMPLE, 5, 5, 5, 0, 0, 0, 32'h0000_02FF, 0);
    rows.push_back(rw);
    rw.item = mk(imuai_pkg::MODE_CLR_ANG, 0, 0, 0, 0, 0, 0, 0, 3'b101); rows.push_back(rw);
    rw.item = mk(imuai_pkg::MODE_CLR_PEAK, 0, 0, 0, 0, 0, 0, 0, 3'b010); rows.push_back(rw);
    rw.item = mk(imuai_pkg::MODE_CLR_ANG, 0, 0, 0, 0, 0, 0, 0, 3'b010); rows.push_back(rw);
    rw.item = mk(imuai_pkg::MODE_CLR_PEAK, 0, 0, 0, 0, 0, 0, 0, 3'b101); rows.push_back(rw);
    // unused modes are ignored
    t = mk(imuai_pkg::MODE_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 7);
    t.mode = 3'd5; rw.item = t; rows.push_back(rw);
    t.mode = 3'd7; rw.item = t; rows.push_back(rw);
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].res);
    rows.delete();

    // Calibration of three: start, restart, load mid-run, end
    write_count(3);
    send_item(mk(imuai_pkg::MODE_CAL, 0, 0, 0, 0, 0, 0, 0, 0), 0, z);
    send_item(mk(imuai_pkg::MODE_SAMPLE, 100, 100, 100, 100, 100, 100, 1, 0), 0, z);
    send_item(mk(imuai_pkg::MODE_CAL, 0, 0, 0, 0, 0, 0, 0, 0), 0, z);
    send_item(mk(imuai_pkg::MODE_SAMPLE, -7, 7, -32768, 32767, -1, 2, 2, 0), 0, z);
    send_item(mk(imuai_pkg::MODE_LOAD_OFS, 9, 9, 9, 9, 9, 9, 0, 0), 0, z);
    send_item(mk(imuai_pkg::MODE_SAMPLE, -1, 1, -32768, 32767, 0, 0, 3, 0), 0, z);
    send_item(mk(imuai_pkg::MODE_SAMPLE, -1, 1, -32768, 32767, 0, 0, 4, 0), 0, z);

    // Count lowered during a run: next sample ends it
    write_count(255);
    send_item(mk(imuai_pkg::MODE_CAL, 0, 0, 0, 0, 0, 0, 0, 0), 0, z);
    send_item(rand_sample($urandom), 0, z);
    send_item(rand_sample($urandom), 0, z);
    write_count(1);
    send_item(rand_sample($urandom), 0, z);

    // Full-length run at the maximum count with extreme raw values
    write_count(255);
    send_item(mk(imuai_pkg::MODE_CAL, 0, 0, 0, 0, 0, 0, 0, 0), 0, z);
    for (int i = 0; i < 255; i++)
      send_item(mk(imuai_pkg::MODE_SAMPLE, -32768, 32767, -32768, 32767, -32768, 32767,
                   i, 0), 0, z);

    // Random part: phases with different counts; one phase without idling
    now = $urandom;
    for (int ph = 0; ph < 8; ph++) begin
      write_count(ph == 7 ? 0 : $urandom_range(1, 12));
      quiet = (ph == 3);
      for (int i = 0; i < 65; i++) begin
        k = $urandom_range(99);
        now = now + (($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 40));
        if (k < 70) t = rand_sample(now);
        else if (k < 78) t = mk(imuai_pkg::MODE_CAL, 0, 0, 0, 0, 0, 0, 0, 0);
        else if (k < 84) t = rand_item();
        else begin
          t = rand_item();
          t.mode = imuai_pkg::mode_t'($urandom_range(2, 4));
        end
        if (k >= 78 && k < 84) t.mode = 3'($urandom_range(0, 7));
        if ($urandom_range(3) == 0) begin
          // small rates keep offsets and angles near zero sometimes
          t.rate_x = 16'($urandom_range(0, 20) - 10);
          t.rate_y = 16'($urandom_range(0, 20) - 10);
        end
        send_item(t, 0, z);
      end
      quiet = 1'b0;
    end

    // Drain
    in_valid <= 1'b0;
    guard = 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    if (err_count == 0 && expected_q.size() == 0)
      $display("imu_angle_integrator_with_calibration regression: pass");
    else
      $display("imu_angle_integrator_with_calibration regression: fail");
    $finish;
  end

endmodule

// ===== imu_angle_integrator_with_calibration.f =====
design/imuai_pkg.sv
design/imuai_ctrl.sv
design/imuai_dp.sv
design/imu_angle_integrator_with_calibration.sv
design/imuai_chk.sv
verif/tb_imu_angle_integrator_with_calibration.sv
